// File: src/mts_pkg.sv
// Package for the memory test sequencer: codes, widths and the walking-pattern table.
package mts_pkg;

  localparam int DATA_W  = 32;
  localparam int OFF_W   = 30;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 32;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_TEST_MODE     = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WORD_COUNT    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_QUICK_PATTERN = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_DESCENDING    = 2'd3;

  localparam logic [OFF_W-1:0]  WORD_COUNT_RST = 30'd1024;
  localparam logic [DATA_W-1:0] ADDR_PATTERN   = 32'haaaaaaaa;
  localparam logic [DATA_W-1:0] ADDR_ANTI      = 32'h55555555;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_ABORT   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_WRITE = 2'd1,
    ACC_READ  = 2'd2
  } acc_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_DL     = 4'd1,
    PH_AFILL  = 4'd2,
    PH_HANTI  = 4'd3,
    PH_HREAD  = 4'd4,
    PH_HREST  = 4'd5,
    PH_LANTI  = 4'd6,
    PH_LREAD  = 4'd7,
    PH_LREST  = 4'd8,
    PH_IFILL  = 4'd9,
    PH_ICHECK = 4'd10,
    PH_IZERO  = 4'd11,
    PH_DONE   = 4'd12,
    PH_QFILL  = 4'd13,
    PH_QREAD  = 4'd14,
    PH_ABORT  = 4'd15
  } phase_t;

  // Base values of the data-line walk; each is shifted left until it leaves the word.
  function automatic logic [DATA_W-1:0] walk_base(input logic [2:0] idx);
    logic [DATA_W-1:0] val;
    case (idx)
      3'd0:    val = 32'h00000001;
      3'd1:    val = 32'h00000003;
      3'd2:    val = 32'h00000007;
      3'd3:    val = 32'h0000000F;
      3'd4:    val = 32'h00000005;
      3'd5:    val = 32'h00000015;
      3'd6:    val = 32'h00000055;
      default: val = 32'haaaaaaaa;
    endcase
    return val;
  endfunction

endpackage

// File: src/mts_in_if.sv
// Request channel into the memory test sequencer.
interface mts_in_if
  import mts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, output command, output read_data, input ready);
  modport sink   (input valid, input command, input read_data, output ready);
endinterface

// File: src/mts_out_if.sv
// Result channel out of the memory test sequencer.
interface mts_out_if
  import mts_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        access;
  logic              to_parking;
  logic [OFF_W-1:0]  word_offset;
  logic [DATA_W-1:0] write_data;
  logic              mismatch;
  logic [DATA_W-1:0] error_count;
  logic              finished;
  logic              aborted;

  modport source (output valid, output access, output to_parking, output word_offset,
                  output write_data, output mismatch, output error_count,
                  output finished, output aborted, input ready);
  modport sink   (input valid, input access, input to_parking, input word_offset,
                  input write_data, input mismatch, input error_count,
                  input finished, input aborted, output ready);
endinterface

// File: src/memory_test_sequencer_top.sv
// Top level of the memory test sequencer: request register, step logic, result register.
//
// Usage: each request on in_ch carries a command (start, advance, abort) and the data
// returned by the memory for the read issued on the previous advance. Each request
// yields exactly one result on out_ch: the memory access to perform (none, write or
// read), its word offset, write data and parking flag, plus the compare outcome,
// the saturating error count and the finished/aborted status.
// A request taken into the request register is processed by the combinational step
// logic and registered in the result register, from which out_ch can take it.
// Throughput is one request per cycle while the receiver takes results: the step logic
// is a single pass over the sequencer state, so a new request can enter every clock.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes test_mode, word_count,
// quick_pattern, descending; user must write with no test request in flight (unchecked).
// Reset (rst_n low, synchronous) empties both registers, puts the sequencer in idle
// and loads the register defaults (word_count 1024, others zero).
// When the receiver stalls, the result register holds its value; the request register
// still takes one more request, and then in_ch.ready drops until the result is taken.
module memory_test_sequencer_top
  import mts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mts_in_if.sink            in_ch,
  mts_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  // Configuration registers.
  logic              test_mode_r;
  logic [OFF_W-1:0]  word_count_r;
  logic [DATA_W-1:0] quick_pattern_r;
  logic              descending_r;

  // Request register.
  logic              in_valid_r;
  logic [1:0]        command_r;
  logic [DATA_W-1:0] read_data_r;

  // Sequencer state.
  phase_t            phase_r, phase_nxt;
  logic [2:0]        sub_step_r, sub_step_nxt;
  logic [2:0]        pattern_index_r, pattern_index_nxt;
  logic [DATA_W-1:0] walking_r, walking_nxt;
  logic [OFF_W-1:0]  probe_r, probe_nxt;
  logic [OFF_W-1:0]  scan_r, scan_nxt;
  logic [DATA_W-1:0] seq_r, seq_nxt;
  logic [DATA_W-1:0] expected_r, expected_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic [DATA_W-1:0] total_r, total_nxt;

  // Result register.
  logic              out_valid_r;
  acc_t              access_r, access_nxt;
  logic              park_r, park_nxt;
  logic [OFF_W-1:0]  offset_r, offset_nxt;
  logic [DATA_W-1:0] wdata_r, wdata_nxt;
  logic              mism_r, mism_nxt;
  logic [DATA_W-1:0] count_r;
  logic              finished_r;
  logic              aborted_r;

  logic              step_en;

  // Power-of-two and linear offset steps, with their end conditions.
  logic [OFF_W:0]    probe_dbl, scan_dbl, scan_inc, wc_ext, wc_plus1;
  logic              probe_pow_ok, scan_pow_ok, lin_ok_wc, lin_ok_wc1;
  logic [DATA_W-1:0] quick_start;
  logic [DATA_W-1:0] seq_step;

  assign step_en     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step_en;

  assign probe_dbl    = {probe_r, 1'b0};
  assign scan_dbl     = {scan_r, 1'b0};
  assign scan_inc     = {1'b0, scan_r} + {{OFF_W{1'b0}}, 1'b1};
  assign wc_ext       = {1'b0, word_count_r};
  assign wc_plus1     = wc_ext + {{OFF_W{1'b0}}, 1'b1};
  assign probe_pow_ok = !probe_dbl[OFF_W] && (probe_dbl < wc_ext);
  assign scan_pow_ok  = !scan_dbl[OFF_W] && (scan_dbl < wc_ext);
  assign lin_ok_wc    = !scan_inc[OFF_W] && (scan_inc < wc_ext);
  assign lin_ok_wc1   = !scan_inc[OFF_W] && (scan_inc < wc_plus1);

  // First value of the quick sweep; the descending sweep negates or inverts it.
  always_comb begin
    quick_start = quick_pattern_r;
    if (descending_r) begin
      quick_start = quick_pattern_r[DATA_W-1] ? (~quick_pattern_r + 1'b1) : ~quick_pattern_r;
    end
  end

  assign seq_step = descending_r ? {DATA_W{1'b1}} : {{(DATA_W-1){1'b0}}, 1'b1};

  // Step logic: compare the returned read, issue one access, advance the phase.
  always_comb begin
    logic              bgn;
    phase_t            bgn_ph;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] shifted;

    bgn               = 1'b0;
    bgn_ph            = PH_IDLE;
    v                 = walking_r;
    shifted           = {walking_r[DATA_W-2:0], 1'b0};
    phase_nxt         = phase_r;
    sub_step_nxt      = sub_step_r;
    pattern_index_nxt = pattern_index_r;
    walking_nxt       = walking_r;
    probe_nxt         = probe_r;
    scan_nxt          = scan_r;
    seq_nxt           = seq_r;
    expected_nxt      = expected_r;
    awaiting_nxt      = awaiting_r;
    total_nxt         = total_r;
    access_nxt        = ACC_NONE;
    park_nxt          = 1'b0;
    offset_nxt        = '0;
    wdata_nxt         = '0;
    mism_nxt          = 1'b0;

    case (command_r)
      CMD_START: begin
        total_nxt    = '0;
        awaiting_nxt = 1'b0;
        bgn          = 1'b1;
        bgn_ph       = test_mode_r ? PH_QFILL : PH_DL;
      end
      CMD_ABORT: begin
        awaiting_nxt = 1'b0;
        phase_nxt    = PH_ABORT;
      end
      CMD_ADVANCE: begin
        // Check the data returned for the previous read.
        if (awaiting_r) begin
          awaiting_nxt = 1'b0;
          if (read_data_r != expected_r) begin
            mism_nxt = 1'b1;
            if (total_r != {DATA_W{1'b1}}) begin
              total_nxt = total_r + 1'b1;
            end
          end
        end

        // Issue the access of the current phase.
        case (phase_r)
          PH_DL: begin
            case (sub_step_r)
              3'd0: begin
                access_nxt = ACC_WRITE;
                wdata_nxt  = v;
              end
              3'd1: begin
                access_nxt = ACC_WRITE;
                park_nxt   = 1'b1;
                wdata_nxt  = ~v;
              end
              3'd2: begin
                access_nxt   = ACC_READ;
                expected_nxt = v;
                awaiting_nxt = 1'b1;
              end
              3'd3: begin
                access_nxt = ACC_WRITE;
                wdata_nxt  = ~v;
              end
              3'd4: begin
                access_nxt = ACC_WRITE;
                park_nxt   = 1'b1;
                wdata_nxt  = v;
              end
              default: begin
                access_nxt   = ACC_READ;
                expected_nxt = ~v;
                awaiting_nxt = 1'b1;
              end
            endcase
            if (sub_step_r < 3'd5) begin
              sub_step_nxt = sub_step_r + 1'b1;
            end else begin
              sub_step_nxt = '0;
              walking_nxt  = shifted;
              if (shifted == '0) begin
                if (pattern_index_r == 3'd7) begin
                  bgn    = 1'b1;
                  bgn_ph = PH_AFILL;
                end else begin
                  pattern_index_nxt = pattern_index_r + 1'b1;
                  walking_nxt       = walk_base(pattern_index_r + 1'b1);
                end
              end
            end
          end
          PH_AFILL: begin
            access_nxt = ACC_WRITE;
            offset_nxt = probe_r;
            wdata_nxt  = ADDR_PATTERN;
            if (probe_pow_ok) begin
              probe_nxt = probe_dbl[OFF_W-1:0];
            end else begin
              bgn    = 1'b1;
              bgn_ph = PH_HANTI;
            end
          end
          PH_HANTI: begin
            access_nxt = ACC_WRITE;
            wdata_nxt  = ADDR_ANTI;
            bgn        = 1'b1;
            bgn_ph     = PH_HREAD;
          end
          PH_HREAD: begin
            access_nxt   = ACC_READ;
            offset_nxt   = scan_r;
            expected_nxt = ADDR_PATTERN;
            awaiting_nxt = 1'b1;
            if (scan_pow_ok) begin
              scan_nxt = scan_dbl[OFF_W-1:0];
            end else begin
              bgn    = 1'b1;
              bgn_ph = PH_HREST;
            end
          end
          PH_HREST: begin
            access_nxt = ACC_WRITE;
            wdata_nxt  = ADDR_PATTERN;
            bgn        = 1'b1;
            bgn_ph     = PH_LANTI;
          end
          PH_LANTI: begin
            access_nxt = ACC_WRITE;
            offset_nxt = probe_r;
            wdata_nxt  = ADDR_ANTI;
            bgn        = 1'b1;
            bgn_ph     = PH_LREAD;
          end
          PH_LREAD: begin
            // The probed word itself holds the inverse pattern and is not compared.
            access_nxt   = ACC_READ;
            offset_nxt   = scan_r;
            expected_nxt = ADDR_PATTERN;
            awaiting_nxt = (scan_r != probe_r);
            if (scan_pow_ok) begin
              scan_nxt = scan_dbl[OFF_W-1:0];
            end else begin
              bgn    = 1'b1;
              bgn_ph = PH_LREST;
            end
          end
          PH_LREST: begin
            access_nxt = ACC_WRITE;
            offset_nxt = probe_r;
            wdata_nxt  = ADDR_PATTERN;
            if (probe_pow_ok) begin
              probe_nxt = probe_dbl[OFF_W-1:0];
              phase_nxt = PH_LANTI;
            end else begin
              bgn    = 1'b1;
              bgn_ph = PH_IFILL;
            end
          end
          PH_IFILL: begin
            access_nxt = ACC_WRITE;
            offset_nxt = scan_r;
            wdata_nxt  = seq_r;
            seq_nxt    = seq_r + 1'b1;
            if (lin_ok_wc1) begin
              scan_nxt = scan_inc[OFF_W-1:0];
            end else begin
              bgn    = 1'b1;
              bgn_ph = PH_ICHECK;
            end
          end
          PH_ICHECK, PH_IZERO: begin
            offset_nxt = scan_r;
            if (sub_step_r == '0) begin
              access_nxt   = ACC_READ;
              expected_nxt = (phase_r == PH_ICHECK) ? seq_r : ~seq_r;
              awaiting_nxt = 1'b1;
              sub_step_nxt = 3'd1;
            end else begin
              access_nxt   = ACC_WRITE;
              wdata_nxt    = (phase_r == PH_ICHECK) ? ~seq_r : '0;
              sub_step_nxt = '0;
              seq_nxt      = seq_r + 1'b1;
              if (lin_ok_wc1) begin
                scan_nxt = scan_inc[OFF_W-1:0];
              end else begin
                bgn    = 1'b1;
                bgn_ph = (phase_r == PH_ICHECK) ? PH_IZERO : PH_DONE;
              end
            end
          end
          PH_QFILL, PH_QREAD: begin
            offset_nxt = scan_r;
            if (phase_r == PH_QFILL) begin
              access_nxt = ACC_WRITE;
              wdata_nxt  = seq_r;
            end else begin
              access_nxt   = ACC_READ;
              expected_nxt = seq_r;
              awaiting_nxt = 1'b1;
            end
            seq_nxt = seq_r + seq_step;
            if (lin_ok_wc) begin
              scan_nxt = scan_inc[OFF_W-1:0];
            end else begin
              bgn    = 1'b1;
              bgn_ph = (phase_r == PH_QFILL) ? PH_QREAD : PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // Entry into a new phase; the address checks skip ahead on a region below two words.
    if (bgn) begin
      sub_step_nxt = '0;
      case (bgn_ph)
        PH_DL: begin
          pattern_index_nxt = '0;
          walking_nxt       = walk_base(3'd0);
          phase_nxt         = PH_DL;
        end
        PH_AFILL: begin
          if (word_count_r > 30'd1) begin
            probe_nxt = 30'd1;
            phase_nxt = PH_AFILL;
          end else begin
            phase_nxt = PH_HANTI;
          end
        end
        PH_HREAD: begin
          if (word_count_r > 30'd1) begin
            scan_nxt  = 30'd1;
            phase_nxt = PH_HREAD;
          end else begin
            phase_nxt = PH_HREST;
          end
        end
        PH_LANTI: begin
          if (word_count_r > 30'd1) begin
            probe_nxt = 30'd1;
            phase_nxt = PH_LANTI;
          end else begin
            scan_nxt  = '0;
            seq_nxt   = 32'd1;
            phase_nxt = PH_IFILL;
          end
        end
        PH_LREAD: begin
          scan_nxt  = 30'd1;
          phase_nxt = PH_LREAD;
        end
        PH_IFILL, PH_ICHECK, PH_IZERO: begin
          scan_nxt  = '0;
          seq_nxt   = 32'd1;
          phase_nxt = bgn_ph;
        end
        PH_QFILL: begin
          if (word_count_r != '0) begin
            scan_nxt  = '0;
            seq_nxt   = quick_start;
            phase_nxt = PH_QFILL;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_QREAD: begin
          scan_nxt  = '0;
          seq_nxt   = quick_start;
          phase_nxt = PH_QREAD;
        end
        default: begin
          phase_nxt = bgn_ph;
        end
      endcase
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_mode_r     <= 1'b0;
      word_count_r    <= WORD_COUNT_RST;
      quick_pattern_r <= '0;
      descending_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEST_MODE:     test_mode_r     <= cfg_wdata[0];
        CFG_WORD_COUNT:    word_count_r    <= cfg_wdata[OFF_W-1:0];
        CFG_QUICK_PATTERN: quick_pattern_r <= cfg_wdata[DATA_W-1:0];
        CFG_DESCENDING:    descending_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      command_r   <= in_ch.command;
      read_data_r <= in_ch.read_data;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      sub_step_r      <= '0;
      pattern_index_r <= '0;
      walking_r       <= '0;
      probe_r         <= '0;
      scan_r          <= '0;
      seq_r           <= '0;
      expected_r      <= '0;
      awaiting_r      <= 1'b0;
      total_r         <= '0;
    end else if (step_en) begin
      phase_r         <= phase_nxt;
      sub_step_r      <= sub_step_nxt;
      pattern_index_r <= pattern_index_nxt;
      walking_r       <= walking_nxt;
      probe_r         <= probe_nxt;
      scan_r          <= scan_nxt;
      seq_r           <= seq_nxt;
      expected_r      <= expected_nxt;
      awaiting_r      <= awaiting_nxt;
      total_r         <= total_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      access_r   <= access_nxt;
      park_r     <= park_nxt;
      offset_r   <= offset_nxt;
      wdata_r    <= wdata_nxt;
      mism_r     <= mism_nxt;
      count_r    <= total_nxt;
      finished_r <= (phase_nxt == PH_DONE) && !awaiting_nxt;
      aborted_r  <= (phase_nxt == PH_ABORT);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.access      = access_r;
  assign out_ch.to_parking  = park_r;
  assign out_ch.word_offset = offset_r;
  assign out_ch.write_data  = wdata_r;
  assign out_ch.mismatch    = mism_r;
  assign out_ch.error_count = count_r;
  assign out_ch.finished    = finished_r;
  assign out_ch.aborted     = aborted_r;

  // A reported mismatch always leaves a nonzero error count.
  a_mism_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mism_r |-> count_r != '0)
    else $error("mismatch reported with zero error count");

  // Finished and aborted are never reported together.
  a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(finished_r && aborted_r))
    else $error("finished and aborted both set");

  // Parking accesses are always writes.
  a_park_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && park_r |-> access_r == ACC_WRITE)
    else $error("parking access that is not a write");

  // An outstanding read exists only inside a running or completed test.
  a_await_phase: assert property (@(posedge clk) disable iff (!rst_n)
    awaiting_r |-> phase_r != PH_IDLE && phase_r != PH_ABORT)
    else $error("outstanding read while idle or aborted");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the memory test sequencer with its own step-by-step access predictor.
module testbench;
  import mts_pkg::*;

  localparam logic [1:0]       CMD_RESERVED = 2'd3;
  localparam int               CYCLE_LIMIT  = 500000;
  localparam logic [63:0]      OFF_MASK     = 64'h3fff_ffff;
  localparam logic [7:0][31:0] WALK_SEEDS   = {32'haaaaaaaa, 32'h00000055, 32'h00000015,
                                               32'h00000005, 32'h0000000f, 32'h00000007,
                                               32'h00000003, 32'h00000001};

  typedef struct packed {
    logic [1:0]  access;
    logic        park;
    logic [29:0] off;
    logic [31:0] wdata;
    logic        mism;
    logic [31:0] errs;
    logic        done;
    logic        stop;
  } mem_step_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  mts_in_if  req_if();
  mts_out_if res_if();

  memory_test_sequencer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_if),
    .out_ch    (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the registers and the sequencer state.
  logic        cfg_mode;
  logic [29:0] cfg_words;
  logic [31:0] cfg_seed;
  logic        cfg_down;
  phase_t      st_phase;
  logic [2:0]  st_sub;
  logic [2:0]  st_pat_idx;
  logic [31:0] st_walk;
  logic [63:0] st_probe;
  logic [63:0] st_scan;
  logic [31:0] st_seq;
  logic [31:0] st_want;
  logic        st_pending;
  logic [31:0] st_errs;
  mem_step_t   step_out;

  mem_step_t expected_accesses[$];
  int        items_sent  = 0;
  int        results_got = 0;
  int        failures    = 0;
  int        cycle_count = 0;
  bit        req_calm    = 1'b0;
  bit        res_calm    = 1'b0;
  bit        spoil_next  = 1'b0;

  function automatic void reset_model();
    cfg_mode   = 1'b0;
    cfg_words  = WORD_COUNT_RST;
    cfg_seed   = 32'd0;
    cfg_down   = 1'b0;
    st_phase   = PH_IDLE;
    st_sub     = 3'd0;
    st_pat_idx = 3'd0;
    st_walk    = 32'd0;
    st_probe   = 64'd0;
    st_scan    = 64'd0;
    st_seq     = 32'd0;
    st_want    = 32'd0;
    st_pending = 1'b0;
    st_errs    = 32'd0;
  endfunction

  // First value of the quick sweep; a descending sweep starts from the flipped pattern.
  function automatic logic [31:0] quick_first();
    if (!cfg_down) return cfg_seed;
    return cfg_seed[31] ? 32'd0 - cfg_seed : ~cfg_seed;
  endfunction

  // Next power-of-two offset still inside the region.
  function automatic bit pow_ok(input logic [63:0] v);
    logic [63:0] nxt;
    nxt = v << 1;
    return (nxt < {34'd0, cfg_words}) && (nxt <= OFF_MASK);
  endfunction

  function automatic bit lin_ok(input logic [63:0] v, input logic [63:0] limit);
    logic [63:0] nxt;
    nxt = v + 64'd1;
    return (nxt < limit) && (nxt <= OFF_MASK);
  endfunction

  function automatic void mem_write(input logic [63:0] off, input logic [31:0] data,
                                    input logic park);
    step_out.access = ACC_WRITE;
    step_out.park   = park;
    step_out.off    = park ? 30'd0 : off[29:0];
    step_out.wdata  = data;
  endfunction

  function automatic void mem_read(input logic [63:0] off, input logic [31:0] want,
                                   input logic check);
    step_out.access = ACC_READ;
    step_out.park   = 1'b0;
    step_out.off    = off[29:0];
    step_out.wdata  = 32'd0;
    st_want         = want;
    st_pending      = check;
  endfunction

  // Entry into a pass; the address passes fall through when the region is too small.
  function automatic void enter_phase(input phase_t p);
    st_sub = 3'd0;
    case (p)
      PH_DL: begin
        st_pat_idx = 3'd0;
        st_walk    = WALK_SEEDS[0];
        st_phase   = p;
      end
      PH_AFILL: begin
        if (cfg_words > 30'd1) begin
          st_probe = 64'd1;
          st_phase = p;
        end else st_phase = PH_HANTI;
      end
      PH_HREAD: begin
        if (cfg_words > 30'd1) begin
          st_scan  = 64'd1;
          st_phase = p;
        end else st_phase = PH_HREST;
      end
      PH_LANTI: begin
        if (cfg_words > 30'd1) begin
          st_probe = 64'd1;
          st_phase = p;
        end else begin
          st_scan  = 64'd0;
          st_seq   = 32'd1;
          st_phase = PH_IFILL;
        end
      end
      PH_LREAD: begin
        st_scan  = 64'd1;
        st_phase = p;
      end
      PH_IFILL, PH_ICHECK, PH_IZERO: begin
        st_scan  = 64'd0;
        st_seq   = 32'd1;
        st_phase = p;
      end
      PH_QFILL: begin
        if (cfg_words != 30'd0) begin
          st_scan  = 64'd0;
          st_seq   = quick_first();
          st_phase = p;
        end else st_phase = PH_DONE;
      end
      PH_QREAD: begin
        st_scan  = 64'd0;
        st_seq   = quick_first();
        st_phase = p;
      end
      default: st_phase = p;
    endcase
  endfunction

  // One memory access of the current pass, then the move to the next one.
  function automatic void issue_access();
    logic [31:0] v;
    v = st_walk;
    case (st_phase)
      PH_DL: begin
        case (st_sub)
          3'd0:    mem_write(64'd0, v, 1'b0);
          3'd1:    mem_write(64'd0, ~v, 1'b1);
          3'd2:    mem_read(64'd0, v, 1'b1);
          3'd3:    mem_write(64'd0, ~v, 1'b0);
          3'd4:    mem_write(64'd0, v, 1'b1);
          default: mem_read(64'd0, ~v, 1'b1);
        endcase
        if (st_sub < 3'd5) st_sub = st_sub + 3'd1;
        else begin
          st_sub  = 3'd0;
          st_walk = v << 1;
          if (st_walk == 32'd0) begin
            if (st_pat_idx >= 3'd7) enter_phase(PH_AFILL);
            else begin
              st_pat_idx = st_pat_idx + 3'd1;
              st_walk    = WALK_SEEDS[st_pat_idx];
            end
          end
        end
      end
      PH_AFILL: begin
        mem_write(st_probe, ADDR_PATTERN, 1'b0);
        if (pow_ok(st_probe)) st_probe = st_probe << 1;
        else enter_phase(PH_HANTI);
      end
      PH_HANTI: begin
        mem_write(64'd0, ADDR_ANTI, 1'b0);
        enter_phase(PH_HREAD);
      end
      PH_HREAD: begin
        mem_read(st_scan, ADDR_PATTERN, 1'b1);
        if (pow_ok(st_scan)) st_scan = st_scan << 1;
        else enter_phase(PH_HREST);
      end
      PH_HREST: begin
        mem_write(64'd0, ADDR_PATTERN, 1'b0);
        enter_phase(PH_LANTI);
      end
      PH_LANTI: begin
        mem_write(st_probe, ADDR_ANTI, 1'b0);
        enter_phase(PH_LREAD);
      end
      PH_LREAD: begin
        // The probed word itself holds the anti-pattern and is read unchecked.
        mem_read(st_scan, ADDR_PATTERN, st_scan != st_probe);
        if (pow_ok(st_scan)) st_scan = st_scan << 1;
        else enter_phase(PH_LREST);
      end
      PH_LREST: begin
        mem_write(st_probe, ADDR_PATTERN, 1'b0);
        if (pow_ok(st_probe)) begin
          st_probe = st_probe << 1;
          st_phase = PH_LANTI;
        end else enter_phase(PH_IFILL);
      end
      PH_IFILL: begin
        mem_write(st_scan, st_seq, 1'b0);
        st_seq = st_seq + 32'd1;
        if (lin_ok(st_scan, cfg_words + 64'd1)) st_scan = st_scan + 64'd1;
        else enter_phase(PH_ICHECK);
      end
      PH_ICHECK, PH_IZERO: begin
        if (st_sub == 3'd0) begin
          mem_read(st_scan, (st_phase == PH_ICHECK) ? st_seq : ~st_seq, 1'b1);
          st_sub = 3'd1;
        end else begin
          mem_write(st_scan, (st_phase == PH_ICHECK) ? ~st_seq : 32'd0, 1'b0);
          st_sub = 3'd0;
          st_seq = st_seq + 32'd1;
          if (lin_ok(st_scan, cfg_words + 64'd1)) st_scan = st_scan + 64'd1;
          else enter_phase((st_phase == PH_ICHECK) ? PH_IZERO : PH_DONE);
        end
      end
      PH_QFILL, PH_QREAD: begin
        if (st_phase == PH_QFILL) mem_write(st_scan, st_seq, 1'b0);
        else mem_read(st_scan, st_seq, 1'b1);
        st_seq = cfg_down ? st_seq - 32'd1 : st_seq + 32'd1;
        if (lin_ok(st_scan, {34'd0, cfg_words})) st_scan = st_scan + 64'd1;
        else enter_phase((st_phase == PH_QFILL) ? PH_QREAD : PH_DONE);
      end
      default: ;
    endcase
  endfunction

  // Expected result of one request; updates the predictor state.
  function automatic mem_step_t sequencer_step(input logic [1:0] cmd, input logic [31:0] rd);
    step_out        = '0;
    step_out.access = ACC_NONE;
    case (cmd)
      CMD_START: begin
        st_errs    = 32'd0;
        st_pending = 1'b0;
        enter_phase(cfg_mode ? PH_QFILL : PH_DL);
      end
      CMD_ABORT: begin
        st_pending = 1'b0;
        st_phase   = PH_ABORT;
      end
      CMD_ADVANCE: begin
        if (st_pending) begin
          st_pending = 1'b0;
          if (rd != st_want) begin
            step_out.mism = 1'b1;
            if (st_errs != 32'hffff_ffff) st_errs = st_errs + 32'd1;
          end
        end
        issue_access();
      end
      default: ;
    endcase
    step_out.errs = st_errs;
    step_out.done = (st_phase == PH_DONE) && !st_pending;
    step_out.stop = (st_phase == PH_ABORT);
    return step_out;
  endfunction

  // Sends one request; the read data usually matches what the pending read expects.
  task automatic send_cmd(input logic [1:0] cmd);
    logic [31:0] rd;
    int          gap;
    gap = req_calm ? 0 : $urandom_range(0, 6);
    if (spoil_next) rd = ~st_want;
    else if (st_pending && cmd == CMD_ADVANCE) begin
      case ($urandom_range(0, 19))
        0:       rd = $urandom();
        1:       rd = st_want ^ (32'd1 << $urandom_range(0, 31));
        default: rd = st_want;
      endcase
    end else rd = $urandom();
    spoil_next = 1'b0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.read_data <= rd;
    do @(posedge clk); while (!req_if.ready);
    expected_accesses.push_back(sequencer_step(cmd, rd));
    items_sent++;
    if (items_sent % 50 == 0) req_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic advance_step();
    if ($urandom_range(0, 39) == 0) send_cmd(CMD_RESERVED);
    send_cmd(CMD_ADVANCE);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Waits until every result is back, then writes all four registers.
  task automatic program_regs(input logic mode, input logic [29:0] words,
                              input logic [31:0] seed, input logic down);
    req_if.valid <= 1'b0;
    while (expected_accesses.size() != 0) @(posedge clk);
    write_reg(CFG_TEST_MODE, {31'd0, mode});
    write_reg(CFG_WORD_COUNT, {2'd0, words});
    write_reg(CFG_QUICK_PATTERN, seed);
    write_reg(CFG_DESCENDING, {31'd0, down});
    cfg_we    <= 1'b0;
    cfg_mode  = mode;
    cfg_words = words;
    cfg_seed  = seed;
    cfg_down  = down;
  endtask

  // Commands outside a running test, and a short alt run cut by abort.
  task automatic test_idle_commands();
    send_cmd(CMD_ADVANCE);
    send_cmd(CMD_RESERVED);
    send_cmd(CMD_ABORT);
    send_cmd(CMD_ADVANCE);
    send_cmd(CMD_START);
    send_cmd(CMD_ADVANCE);
    send_cmd(CMD_ADVANCE);
    send_cmd(CMD_ABORT);
  endtask

  // Quick sweeps at the edges: empty region, one word, sign-flip start, wrap, huge region.
  task automatic test_quick_edges();
    program_regs(1'b1, 30'd0, 32'hffff_ffff, 1'b0);
    send_cmd(CMD_START);
    send_cmd(CMD_ADVANCE);
    send_cmd(CMD_ADVANCE);

    // The last read of the sweep is still compared by an advance after the end.
    program_regs(1'b1, 30'd1, 32'h8000_0000, 1'b1);
    send_cmd(CMD_START);
    send_cmd(CMD_ADVANCE);
    send_cmd(CMD_ADVANCE);
    spoil_next = 1'b1;
    send_cmd(CMD_ADVANCE);

    program_regs(1'b1, 30'd2, 32'h7fff_ffff, 1'b1);
    send_cmd(CMD_START);
    repeat (5) send_cmd(CMD_ADVANCE);

    program_regs(1'b1, 30'h3fff_ffff, 32'hffff_ffff, 1'b0);
    send_cmd(CMD_START);
    repeat (3) send_cmd(CMD_ADVANCE);
    send_cmd(CMD_ABORT);
  endtask

  // Alt test on a region below two words: the data-line walk, then the address fill skipped.
  task automatic test_alt_tiny();
    program_regs(1'b0, 30'($urandom_range(0, 1)), $urandom(), 1'($urandom_range(0, 1)));
    send_cmd(CMD_START);
    while (st_phase == PH_DL) advance_step();
  endtask

  // The same run widened to 2^29 words for the address reads, then narrowed
  // back before the last restore so the increment passes stay short, and run to the end.
  task automatic test_alt_wide();
    logic [29:0] small_words;
    small_words = cfg_words;
    program_regs(1'b0, 30'h2000_0000, 32'd0, 1'b0);
    while (st_phase != PH_LREST) advance_step();
    program_regs(1'b0, small_words, 32'd0, 1'b0);
    while (!(st_phase == PH_DONE && !st_pending)) advance_step();
    send_cmd(CMD_ADVANCE);
    send_cmd(CMD_ABORT);
    send_cmd(CMD_ADVANCE);
  endtask

  // Random sessions, mostly quick sweeps of small regions run to completion.
  task automatic test_random_sessions();
    int          first_item;
    int          steps;
    int          n;
    logic        mode;
    logic        down;
    logic [29:0] words;
    logic [31:0] seed;
    first_item = items_sent;
    while (items_sent - first_item < 40) begin
      mode = ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
      case ($urandom_range(0, 15))
        0:       words = 30'd0;
        1:       words = 30'h3fff_ffff;
        2:       words = 30'h2000_0000;
        3, 4:    words = 30'($urandom_range(1, 2));
        default: words = 30'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        0:       seed = 32'd0;
        1:       seed = 32'hffff_ffff;
        2:       seed = 32'h8000_0000;
        3:       seed = 32'h7fff_ffff;
        default: seed = $urandom();
      endcase
      down = 1'($urandom_range(0, 1));
      program_regs(mode, words, seed, down);
      if (mode == 1'b0 || words > 30'd40) steps = $urandom_range(4, 60);
      else steps = 2 * words + $urandom_range(0, 3);
      send_cmd(CMD_START);
      for (n = 0; n < steps; n++) begin
        case ($urandom_range(0, 39))
          0:       send_cmd(CMD_RESERVED);
          1:       send_cmd(CMD_START);
          default: send_cmd(CMD_ADVANCE);
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        send_cmd(CMD_ABORT);
        send_cmd(CMD_ADVANCE);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      failures++;
    end
  endtask

  // Result side: random stalls, and each result checked against the oldest prediction.
  initial begin
    mem_step_t want;
    mem_step_t got;
    int        k;
    res_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      k = res_calm ? 0 : $urandom_range(0, 6);
      if (k > 0) begin
        res_if.ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      results_got++;
      if (results_got % 64 == 0) res_calm = ($urandom_range(0, 3) == 0);
      got.access = res_if.access;
      got.park   = res_if.to_parking;
      got.off    = res_if.word_offset;
      got.wdata  = res_if.write_data;
      got.mism   = res_if.mismatch;
      got.errs   = res_if.error_count;
      got.done   = res_if.finished;
      got.stop   = res_if.aborted;
      if (expected_accesses.size() == 0) begin
        $display("%0t: result with no request outstanding, access %h offset %h",
                 $time, got.access, got.off);
        failures++;
      end else begin
        want = expected_accesses.pop_front();
        compare_field("access", {30'd0, want.access}, {30'd0, got.access});
        compare_field("to_parking", {31'd0, want.park}, {31'd0, got.park});
        compare_field("word_offset", {2'd0, want.off}, {2'd0, got.off});
        compare_field("write_data", want.wdata, got.wdata);
        compare_field("mismatch", {31'd0, want.mism}, {31'd0, got.mism});
        compare_field("error_count", want.errs, got.errs);
        compare_field("finished", {31'd0, want.done}, {31'd0, got.done});
        compare_field("aborted", {31'd0, want.stop}, {31'd0, got.stop});
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Reset, the test sequence, and the final verdict.
  initial begin
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.command   <= CMD_START;
    req_if.read_data <= 32'd0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_TEST_MODE;
    cfg_wdata        <= 32'd0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_commands();
    test_quick_edges();
    test_alt_tiny();
    test_alt_wide();
    test_random_sessions();

    req_if.valid <= 1'b0;
    while (expected_accesses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/mts_pkg.sv
src/mts_in_if.sv
src/mts_out_if.sv
src/memory_test_sequencer_top.sv
tb/sv/testbench.sv
